/* rtl/core/cts_pkg.sv */
package cts_pkg;

  // Field widths fixed by the interface.
  localparam int EP_W    = 64;
  localparam int X_W     = 128;
  localparam int OC_W    = 6;
  localparam int ADDR_W  = 16;
  localparam int CNT_W   = 7;

  // Powers of three up to 3^63 fit in 100 bits. The lift multiply works on
  // four 25-bit slices of the power.
  localparam int P3_W     = 100;
  localparam int P3_DEPTH = 64;
  localparam int SLICE_W  = 25;
  localparam int PROD_W   = ADDR_W + SLICE_W;
  localparam int SUM_W    = ADDR_W + P3_W;
  localparam int CAT_W    = 2 * SLICE_W + PROD_W;

  // Default build values.
  localparam int START_DEPTH = 61;
  localparam int TAIL_STEPS  = 17;

  // Upper bound of the minimum-count search.
  localparam int MIN_CNT_CAP = 80;

  typedef logic [P3_W-1:0] pow3_tab_t [P3_DEPTH];

  // One item as it moves along the row of step cells.
  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] cnt;
    logic [X_W-1:0]   x;
  } cts_item_t;

  // Table of 3^i, built at elaboration.
  function automatic pow3_tab_t pow3_table();
    pow3_tab_t      tab;
    logic [P3_W-1:0] p;
    p = P3_W'(1);
    for (int i = 0; i < P3_DEPTH; i++) begin
      tab[i] = p;
      p = p + (p << 1);
    end
    return tab;
  endfunction

  localparam pow3_tab_t POW3 = pow3_table();

  // Least q with 3^q >= 2^depth, evaluated only on constants.
  function automatic int min_count(input int depth);
    logic [X_W-1:0] p;
    logic [X_W-1:0] lim;
    int             q;
    p   = X_W'(1);
    lim = X_W'(1) << depth;
    q   = 0;
    while ((p < lim) && (q < MIN_CNT_CAP)) begin
      p = p + (p << 1);
      q = q + 1;
    end
    return q;
  endfunction

endpackage

/* rtl/core/cts_front.sv */
module cts_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [cts_pkg::EP_W-1:0]     endpoint_low_i,
  input  logic [cts_pkg::EP_W-1:0]     endpoint_high_i,
  input  logic [cts_pkg::OC_W-1:0]     odd_count_i,
  input  logic [cts_pkg::ADDR_W-1:0]   lift_address_i,
  output logic                         valid_o,
  output cts_pkg::cts_item_t           item_o
);

  // Valid bits of the four lift stages.
  logic [3:0] vld_q;

  // Stage one: power of three from the table.
  logic [cts_pkg::X_W-1:0]    ep1_q;
  logic [cts_pkg::CNT_W-1:0]  cnt1_q;
  logic [cts_pkg::ADDR_W-1:0] addr1_q;
  logic [cts_pkg::P3_W-1:0]   p3_q;

  // Stage two: four slice products.
  logic [cts_pkg::X_W-1:0]    ep2_q;
  logic [cts_pkg::CNT_W-1:0]  cnt2_q;
  logic [cts_pkg::PROD_W-1:0] prod_q [4];

  // Stage three: lift term.
  logic [cts_pkg::X_W-1:0]    ep3_q;
  logic [cts_pkg::CNT_W-1:0]  cnt3_q;
  logic [cts_pkg::SUM_W-1:0]  sum_q;

  // Stage four: lifted endpoint.
  logic [cts_pkg::CNT_W-1:0]  cnt4_q;
  logic [cts_pkg::X_W-1:0]    x4_q;

  logic [cts_pkg::CAT_W-1:0]  even_cat;
  logic [cts_pkg::CAT_W-1:0]  odd_cat;
  logic [cts_pkg::SUM_W-1:0]  sum_d;

  // Slices zero and two do not overlap, nor do slices one and three, so each
  // pair is a plain concatenation and one add joins them.
  always_comb begin
    even_cat = {prod_q[2], (2 * cts_pkg::SLICE_W - cts_pkg::PROD_W)'(0), prod_q[0]};
    odd_cat  = {prod_q[3], (2 * cts_pkg::SLICE_W - cts_pkg::PROD_W)'(0), prod_q[1]};
    sum_d    = cts_pkg::SUM_W'(even_cat)
             + cts_pkg::SUM_W'({odd_cat, cts_pkg::SLICE_W'(0)});
  end

  // Stage valid bits move together under the common enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ep1_q   <= {endpoint_high_i, endpoint_low_i};
      cnt1_q  <= cts_pkg::CNT_W'(odd_count_i);
      addr1_q <= lift_address_i;
      p3_q    <= cts_pkg::POW3[odd_count_i];

      ep2_q  <= ep1_q;
      cnt2_q <= cnt1_q;
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= cts_pkg::PROD_W'(addr1_q)
                   * cts_pkg::PROD_W'(p3_q[k*cts_pkg::SLICE_W +: cts_pkg::SLICE_W]);
      end

      ep3_q  <= ep2_q;
      cnt3_q <= cnt2_q;
      sum_q  <= sum_d;

      cnt4_q <= cnt3_q;
      x4_q   <= ep3_q + cts_pkg::X_W'(sum_q);
    end
  end

  assign valid_o     = vld_q[3];
  assign item_o.ok   = 1'b1;
  assign item_o.cnt  = cnt4_q;
  assign item_o.x    = x4_q;

endmodule

/* rtl/core/cts_cell.sv */
module cts_cell #(
  parameter int MIN_CNT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cts_pkg::cts_item_t item_i,
  output logic               valid_o,
  output cts_pkg::cts_item_t item_o
);

  logic                         valid_q;
  cts_pkg::cts_item_t           item_q;
  cts_pkg::cts_item_t           item_d;
  logic                         odd;
  logic [cts_pkg::CNT_W-1:0]    cnt_n;
  logic [cts_pkg::X_W-1:0]      x_sum;

  // One step of the shortcut map. For odd x, 3x+1 is x plus (2x+1), and the
  // halving follows. The count is checked against this depth's minimum.
  always_comb begin
    odd   = item_i.x[0];
    cnt_n = item_i.cnt + cts_pkg::CNT_W'(odd);
    x_sum = odd ? (item_i.x + {item_i.x[cts_pkg::X_W-2:0], 1'b1}) : item_i.x;
    item_d.ok  = item_i.ok && (cnt_n >= cts_pkg::CNT_W'(MIN_CNT));
    item_d.cnt = cnt_n;
    item_d.x   = {1'b0, x_sum[cts_pkg::X_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/core/collatz_tail_survival_step_top.sv */
// Collatz tail survival step.
// Input channel (in_valid_i / in_ready_o) carries one 128-bit endpoint as two
// halves, an odd-step count and a lift address. Output channel
// (out_valid_o / out_ready_i) returns one result per transaction: a survival
// flag and, when it survived, the final endpoint and odd count (else zeros).
// Four stages form the lifted endpoint (power-of-three lookup, slice products,
// lift sum, endpoint add), then one step cell per tail step.
// Throughput is one transaction per cycle; the whole pipeline advances when
// the output register is empty or being taken.
// When the receiver stalls a held result, the pipeline freezes and in_ready_o
// drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the block accepts work as soon as reset is
// released.
module collatz_tail_survival_step_top #(
  parameter int START_DEPTH = cts_pkg::START_DEPTH,
  parameter int TAIL_STEPS  = cts_pkg::TAIL_STEPS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cts_pkg::EP_W-1:0]   endpoint_low_i,
  input  logic [cts_pkg::EP_W-1:0]   endpoint_high_i,
  input  logic [cts_pkg::OC_W-1:0]   odd_count_i,
  input  logic [cts_pkg::ADDR_W-1:0] lift_address_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       survived_o,
  output logic [cts_pkg::EP_W-1:0]   final_low_o,
  output logic [cts_pkg::EP_W-1:0]   final_high_o,
  output logic [cts_pkg::CNT_W-1:0]  final_count_o
);

  localparam int MIN_LAST = cts_pkg::min_count(START_DEPTH + TAIL_STEPS);

  logic               advance;
  logic               chain_valid [TAIL_STEPS+1];
  cts_pkg::cts_item_t chain_item  [TAIL_STEPS+1];
  cts_pkg::cts_item_t last_item;

  // The pipeline moves unless a finished result is waiting.
  assign advance    = out_ready_i || !out_valid_o;
  assign in_ready_o = advance;

  // Lift stages.
  cts_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .valid_i         (in_valid_i),
    .endpoint_low_i  (endpoint_low_i),
    .endpoint_high_i (endpoint_high_i),
    .odd_count_i     (odd_count_i),
    .lift_address_i  (lift_address_i),
    .valid_o         (chain_valid[0]),
    .item_o          (chain_item[0])
  );

  // Row of step cells, one per tail depth.
  for (genvar g = 0; g < TAIL_STEPS; g++) begin : g_cell
    cts_cell #(
      .MIN_CNT (cts_pkg::min_count(START_DEPTH + g + 1))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (chain_valid[g]),
      .item_i  (chain_item[g]),
      .valid_o (chain_valid[g+1]),
      .item_o  (chain_item[g+1])
    );
  end

  // The last cell's register is the output register; failures read as zero.
  assign last_item     = chain_item[TAIL_STEPS];
  assign out_valid_o   = chain_valid[TAIL_STEPS];
  assign survived_o    = last_item.ok;
  assign final_low_o   = last_item.ok ? last_item.x[cts_pkg::EP_W-1:0] : '0;
  assign final_high_o  = last_item.ok ? last_item.x[cts_pkg::X_W-1:cts_pkg::EP_W] : '0;
  assign final_count_o = last_item.ok ? last_item.cnt : '0;

`ifndef NO_ASSERTIONS
  // A survivor met the minimum count of the deepest step.
  a_survivor_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && survived_o |-> final_count_o >= cts_pkg::CNT_W'(MIN_LAST))
    else $error("survivor below final minimum count");

  // The count can grow by at most one per tail step.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> final_count_o <= cts_pkg::CNT_W'(63 + TAIL_STEPS))
    else $error("final count out of range");

  // A stalled result stays in place while the pipeline is frozen.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(final_low_o)
      && $stable(final_high_o) && $stable(survived_o))
    else $error("stalled result changed");

  // No transaction is taken while the output is blocked.
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while output stalled");
`endif

endmodule

/* sim/cts_tail_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the tail survival step, predicts the result of
// every accepted input transaction and compares each output transaction with
// the oldest prediction.
module cts_tail_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [cts_pkg::EP_W-1:0]   endpoint_low_i,
  input  logic [cts_pkg::EP_W-1:0]   endpoint_high_i,
  input  logic [cts_pkg::OC_W-1:0]   odd_count_i,
  input  logic [cts_pkg::ADDR_W-1:0] lift_address_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic                       survived_i,
  input  logic [cts_pkg::EP_W-1:0]   final_low_i,
  input  logic [cts_pkg::EP_W-1:0]   final_high_i,
  input  logic [cts_pkg::CNT_W-1:0]  final_count_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int FIRST_DEPTH = cts_pkg::START_DEPTH;
  localparam int TAIL_STEPS  = cts_pkg::TAIL_STEPS;

  typedef struct packed {
    logic                      survived;
    logic [cts_pkg::EP_W-1:0]  final_low;
    logic [cts_pkg::EP_W-1:0]  final_high;
    logic [cts_pkg::CNT_W-1:0] final_count;
  } tail_outcome_t;

  tail_outcome_t expected_tails[$];
  int            mismatches = 0;

  // Smallest odd count whose power of three reaches 2^depth.
  function automatic int least_odd_count(input int depth);
    logic [cts_pkg::X_W-1:0] pw;
    int                      q;
    pw = cts_pkg::X_W'(1);
    q  = 0;
    while (((pw >> depth) == 0) && (q < cts_pkg::MIN_CNT_CAP)) begin
      pw = pw * 3;
      q++;
    end
    return q;
  endfunction

  // Lift the endpoint, then run the tail steps while the odd count keeps up.
  function automatic tail_outcome_t predict_tail(
    input logic [cts_pkg::EP_W-1:0]   lo,
    input logic [cts_pkg::EP_W-1:0]   hi,
    input logic [cts_pkg::OC_W-1:0]   odd_cnt,
    input logic [cts_pkg::ADDR_W-1:0] addr
  );
    tail_outcome_t           res;
    logic [cts_pkg::X_W-1:0] pow3;
    logic [cts_pkg::X_W-1:0] x;
    int                      cnt;
    bit                      alive;
    pow3 = cts_pkg::X_W'(1);
    for (int i = 0; i < odd_cnt; i++) pow3 = pow3 * 3;
    x     = {hi, lo} + pow3 * cts_pkg::X_W'(addr);
    cnt   = int'(odd_cnt);
    alive = 1'b1;
    for (int j = 1; (j <= TAIL_STEPS) && alive; j++) begin
      cnt += int'(x[0]);
      if (cnt < least_odd_count(FIRST_DEPTH + j)) begin
        alive = 1'b0;
      end else begin
        if (x[0]) x = x * 3 + 1;
        x = x >> 1;
      end
    end
    res = '0;
    if (alive) begin
      res.survived    = 1'b1;
      res.final_low   = x[63:0];
      res.final_high  = x[127:64];
      res.final_count = cnt[cts_pkg::CNT_W-1:0];
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Results are taken before new inputs so that a stray result can never
  // consume a prediction made at the same edge.
  always @(posedge clk_i) begin : watch
    tail_outcome_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_tails.size() == 0) begin
          $error("result transaction arrived with no prediction pending");
          mismatches++;
        end else begin
          want = expected_tails.pop_front();
          check_field("survived", 64'(want.survived), 64'(survived_i));
          check_field("final_low", want.final_low, final_low_i);
          check_field("final_high", want.final_high, final_high_i);
          check_field("final_count", 64'(want.final_count), 64'(final_count_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_tails.insert(expected_tails.size(),
                              predict_tail(endpoint_low_i, endpoint_high_i,
                                           odd_count_i, lift_address_i));
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_tails.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int DRAIN_CYCLES = 4 + cts_pkg::TAIL_STEPS + 16;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 900;

  logic                       clk_i;
  logic                       rst_ni          = 1'b0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_ready_o;
  logic [cts_pkg::EP_W-1:0]   endpoint_low_i  = '0;
  logic [cts_pkg::EP_W-1:0]   endpoint_high_i = '0;
  logic [cts_pkg::OC_W-1:0]   odd_count_i     = '0;
  logic [cts_pkg::ADDR_W-1:0] lift_address_i  = '0;
  logic                       out_valid_o;
  logic                       out_ready_i     = 1'b0;
  logic                       survived_o;
  logic [cts_pkg::EP_W-1:0]   final_low_o;
  logic [cts_pkg::EP_W-1:0]   final_high_o;
  logic [cts_pkg::CNT_W-1:0]  final_count_o;

  int fail_count;
  int pending;
  bit calm        = 1'b0;
  int stall_left  = 0;
  int quiet_ticks = 0;

  collatz_tail_survival_step_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .endpoint_low_i (endpoint_low_i),
    .endpoint_high_i(endpoint_high_i),
    .odd_count_i    (odd_count_i),
    .lift_address_i (lift_address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .survived_o     (survived_o),
    .final_low_o    (final_low_o),
    .final_high_o   (final_high_o),
    .final_count_o  (final_count_o)
  );

  cts_tail_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .endpoint_low_i (endpoint_low_i),
    .endpoint_high_i(endpoint_high_i),
    .odd_count_i    (odd_count_i),
    .lift_address_i (lift_address_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .survived_i     (survived_o),
    .final_low_i    (final_low_o),
    .final_high_i   (final_high_o),
    .final_count_i  (final_count_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: mostly ready, with short stalls and the odd long one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (!calm && ($urandom_range(0, 3) == 0)) begin
      out_ready_i <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_ticks = 0;
      end else begin
        quiet_ticks++;
        if (quiet_ticks >= QUIET_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // Offer one input transaction after a random gap and hold it until taken.
  task automatic send_item(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [5:0] odd_cnt, input logic [15:0] addr);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = calm ? 0 : (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3)
                                             : $urandom_range(6, 30);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    endpoint_low_i  <= lo;
    endpoint_high_i <= hi;
    odd_count_i     <= odd_cnt;
    lift_address_i  <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Hold the sender off until every predicted result has come back.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    logic [63:0] lo;
    logic [63:0] hi;
    logic [5:0]  odd_cnt;
    logic [15:0] addr;
    int          pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: zero and all-ones fields, lift wrap, long odd runs
    // and failure on the very last step.
    send_item('0, '0, 6'd0, 16'h0000);
    send_item('1, '1, 6'd63, 16'hFFFF);
    send_item('1, '0, 6'd40, 16'h0000);
    send_item(64'h1FFFF, '0, 6'd40, 16'h0000);
    send_item(64'h3FF, '0, 6'd40, 16'h0000);
    send_item(64'h1, '0, 6'd39, 16'h0000);
    send_item(64'h2, '0, 6'd39, 16'h0000);
    send_item('0, '0, 6'd61, 16'h0000);
    send_item('0, '1, 6'd62, 16'h0001);
    send_item({$urandom, $urandom}, {$urandom, $urandom}, 6'd63, 16'hFFFF);
    send_item('0, 64'h8000_0000_0000_0000, 6'd50, 16'h0000);
    send_item('1, '1, 6'd0, 16'h0000);
    send_item('1, '1, 6'd49, 16'h0000);
    send_item('0, '0, 6'd0, 16'hFFFF);
    send_item('0, '0, 6'd63, 16'h0001);
    send_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 6'd45, 16'h5555);
    send_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 6'd46, 16'hAAAA);
    send_item('0, '0, 6'd49, 16'h0000);
    send_item('0, '0, 6'd50, 16'h0000);
    drain_pipeline();

    // Random part, weighted toward counts near the survival threshold and
    // endpoints with long runs of odd steps.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ((n % 64) == 0) calm <= ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) drain_pipeline();
      lo   = {$urandom, $urandom};
      hi   = {$urandom, $urandom};
      addr = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 9);
      if (pick < 4) odd_cnt = 6'($urandom_range(38, 52));
      else if (pick < 7) odd_cnt = 6'($urandom_range(0, 63));
      else odd_cnt = 6'($urandom_range(53, 63));
      if ($urandom_range(0, 2) == 0) begin
        lo   = lo | ((64'd1 << $urandom_range(3, 30)) - 64'd1);
        addr = '0;
      end
      send_item(lo, hi, odd_cnt, addr);
    end

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
